/* sv/ltic_pkg.sv */
// Shared widths, request codes and divider handshake types for the
// linear table interpolation core. No dependencies.
package ltic_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int IDX_W = 8;
  localparam int LEN_W = 9;

  localparam int NUM_W     = 65;
  localparam int QUO_STEPS = 33;
  localparam int QUO_W     = 34;
  localparam int CNT_W     = 6;

  localparam logic [LEN_W-1:0] LEN_RESET = 9'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [KEY_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

/* sv/ltic_in_if.sv */
// Input channel: valid/ready handshake with load and query payload.
// Depends on ltic_pkg.
interface ltic_in_if import ltic_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [IDX_W-1:0]        entry_index;
  logic [KEY_W-1:0]        entry_key;
  logic signed [VAL_W-1:0] entry_value;
  logic [KEY_W-1:0]        query_key;

  modport source (
    output valid, req_type, entry_index, entry_key, entry_value, query_key,
    input  ready
  );

  modport sink (
    input  valid, req_type, entry_index, entry_key, entry_value, query_key,
    output ready
  );
endinterface

/* sv/ltic_out_if.sv */
// Result channel: valid/ready handshake with interpolated value.
// Depends on ltic_pkg.
interface ltic_out_if import ltic_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  logic                    in_range;

  modport source (
    output valid, result_value, in_range,
    input  ready
  );

  modport sink (
    input  valid, result_value, in_range,
    output ready
  );
endinterface

/* sv/ltic_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ltic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ltic_div.sv */
// Restoring divider, one quotient bit per cycle, quotient capped at 2^33.
// Depends on ltic_pkg.
module ltic_div import ltic_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [KEY_W-1:0]     den_r;
  logic [KEY_W-1:0]     rem_r;
  logic [QUO_STEPS-1:0] sh_r;
  logic [QUO_STEPS-1:0] quo_r;
  logic [QUO_W-1:0]     res_r;

  logic [KEY_W:0]       trial;
  logic                 qbit;
  logic [KEY_W:0]       diff;
  logic                 done_nxt;

  always_comb begin
    trial = {rem_r, sh_r[QUO_STEPS-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = (trial >= {1'b0, den_r});
    if (req.start) begin
      done_nxt = (req.num[NUM_W-1:QUO_STEPS] >= req.den);
    end else begin
      done_nxt = busy_r && (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= done_nxt;
      if (req.start) begin
        den_r <= req.den;
        if (req.num[NUM_W-1:QUO_STEPS] >= req.den) begin
          res_r  <= QUO_W'(1) << QUO_STEPS;
        end else begin
          rem_r  <= req.num[NUM_W-1:QUO_STEPS];
          sh_r   <= req.num[QUO_STEPS-1:0];
          quo_r  <= '0;
          cnt_r  <= CNT_W'(QUO_STEPS);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= qbit ? diff[KEY_W-1:0] : trial[KEY_W-1:0];
        sh_r  <= {sh_r[QUO_STEPS-2:0], 1'b0};
        quo_r <= {quo_r[QUO_STEPS-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          res_r  <= {1'b0, quo_r[QUO_STEPS-2:0], qbit};
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = res_r;

endmodule

/* sv/linear_table_interpolation_core.sv */
// Piecewise linear interpolation over a (key, value) table in two RAMs.
// Load beat: table written at acceptance; next item taken at once.
// Query beat: the linear key scan (one RAM read per cycle) finds entry i, then
// the 33-step divider forms the quotient. Equal keys or a saturated quotient
// end sooner; out-of-range queries end after the range check. One query in
// flight at a time.
// Reset (rst_n low, synchronous): table_length = 2, no result pending.
module linear_table_interpolation_core import ltic_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ltic_in_if.sink          in_ch,
  ltic_out_if.source       out_ch,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_K0, S_KN, S_CHK, S_SCAN, S_KB, S_VA, S_VB, S_PB,
    S_MUL, S_ADD, S_DIV, S_FIN
  } state_t;

  state_t                  state_r;
  logic [LEN_W-1:0]        tbl_len_r;
  logic [AW-1:0]           last_idx;
  logic [31:0]             len_w;

  logic                    in_acc;
  logic                    load_we;
  logic [AW-1:0]           key_raddr;
  logic [AW-1:0]           val_raddr;
  logic [KEY_W-1:0]        key_rd;
  logic [VAL_W-1:0]        val_rd;

  logic [KEY_W-1:0]        q_r;
  logic [KEY_W-1:0]        k0_r;
  logic [KEY_W-1:0]        prev_r;
  logic [KEY_W-1:0]        ka_r;
  logic [KEY_W-1:0]        kb_r;
  logic [AW-1:0]           i_r;
  logic [AW-1:0]           a_r;
  logic [AW-1:0]           b_r;
  logic [VAL_W-1:0]        pa_r;
  logic [VAL_W-1:0]        pb_r;
  logic                    inr_r;

  logic [VAL_W:0]          dp;
  logic [KEY_W:0]          dq;
  logic [KEY_W:0]          dk;
  logic [VAL_W:0]          mag_dp_r;
  logic [KEY_W-1:0]        mag_dq_r;
  logic [KEY_W-1:0]        mag_dk_r;
  logic                    neg_r;
  logic                    dkz_r;
  logic [2*KEY_W-1:0]      prod_r;
  logic [NUM_W-1:0]        num_r;
  logic                    div_go_r;
  logic [QUO_W-1:0]        quo_r;

  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic signed [VAL_W+3:0] sum;
  logic [VAL_W-1:0]        final_val;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [VAL_W-1:0]        out_res_r;
  logic                    out_inr_r;

  always_comb begin
    len_w = 32'(tbl_len_r);
    if (len_w < 32'd2) begin
      len_w = 32'd2;
    end
    if (len_w > 32'(TABLE_DEPTH)) begin
      len_w = 32'(TABLE_DEPTH);
    end
    last_idx = AW'(len_w - 32'd1);
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_we     = in_acc && (in_ch.req_type == REQ_LOAD) &&
                       (32'(in_ch.entry_index) < 32'(TABLE_DEPTH));

  always_comb begin
    unique case (state_r)
      S_KN:    key_raddr = last_idx;
      S_SCAN:  key_raddr = AW'(i_r + 1'b1);
      default: key_raddr = '0;
    endcase
    val_raddr = (state_r == S_VB) ? b_r : a_r;
  end

  ltic_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(in_ch.entry_index)),
    .wdata (in_ch.entry_key),
    .raddr (key_raddr),
    .rdata (key_rd)
  );

  ltic_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(in_ch.entry_index)),
    .wdata (in_ch.entry_value),
    .raddr (val_raddr),
    .rdata (val_rd)
  );

  always_comb begin
    dp = {val_rd[VAL_W-1], val_rd} - {pa_r[VAL_W-1], pa_r};
    dq = {1'b0, q_r} - {1'b0, ka_r};
    dk = {1'b0, kb_r} - {1'b0, ka_r};
  end

  assign div_req.start = div_go_r;
  assign div_req.num   = num_r;
  assign div_req.den   = mag_dk_r;

  ltic_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    if (neg_r) begin
      sum = {{4{pa_r[VAL_W-1]}}, pa_r} - {2'b00, quo_r};
    end else begin
      sum = {{4{pa_r[VAL_W-1]}}, pa_r} + {2'b00, quo_r};
    end
    if (!inr_r) begin
      final_val = '0;
    end else if (dkz_r) begin
      final_val = pb_r;
    end else if (sum[VAL_W+3:VAL_W-1] == '0 || sum[VAL_W+3:VAL_W-1] == '1) begin
      final_val = sum[VAL_W-1:0];
    end else if (sum[VAL_W+3]) begin
      final_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      final_val = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  assign out_valid_nxt = (state_r == S_FIN) || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tbl_len_r   <= LEN_RESET;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tbl_len_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
      div_go_r    <= (state_r == S_ADD);

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.req_type == REQ_QUERY) begin
            q_r     <= in_ch.query_key;
            state_r <= S_K0;
          end
        end
        S_K0: begin
          state_r <= S_KN;
        end
        S_KN: begin
          k0_r    <= key_rd;
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (q_r < k0_r || q_r > key_rd) begin
            inr_r   <= 1'b0;
            state_r <= S_FIN;
          end else begin
            inr_r   <= 1'b1;
            i_r     <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (q_r <= key_rd || i_r == last_idx) begin
            if (i_r == '0) begin
              a_r     <= '0;
              b_r     <= AW'(1);
              ka_r    <= key_rd;
              state_r <= S_KB;
            end else begin
              a_r     <= AW'(i_r - 1'b1);
              b_r     <= i_r;
              ka_r    <= prev_r;
              kb_r    <= key_rd;
              state_r <= S_VA;
            end
          end else begin
            prev_r <= key_rd;
            i_r    <= AW'(i_r + 1'b1);
          end
        end
        S_KB: begin
          kb_r    <= key_rd;
          state_r <= S_VA;
        end
        S_VA: begin
          state_r <= S_VB;
        end
        S_VB: begin
          pa_r    <= val_rd;
          state_r <= S_PB;
        end
        S_PB: begin
          pb_r     <= val_rd;
          mag_dp_r <= dp[VAL_W] ? (VAL_W+1)'(-dp) : dp;
          mag_dq_r <= dq[KEY_W] ? KEY_W'(-dq) : dq[KEY_W-1:0];
          mag_dk_r <= dk[KEY_W] ? KEY_W'(-dk) : dk[KEY_W-1:0];
          neg_r    <= dp[VAL_W] ^ dq[KEY_W] ^ dk[KEY_W];
          dkz_r    <= (dk == '0);
          state_r  <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= mag_dq_r * mag_dp_r[VAL_W-1:0];
          state_r <= dkz_r ? S_FIN : S_ADD;
        end
        S_ADD: begin
          num_r    <= {1'b0, prod_r} +
                      (mag_dp_r[VAL_W] ? {1'b0, mag_dq_r, {KEY_W{1'b0}}} : '0);
          state_r  <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            quo_r   <= div_rsp.quo;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_res_r   <= final_val;
            out_inr_r   <= inr_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.in_range     = out_inr_r;

endmodule

/* sv/ltic_chk.sv */
// Port-level checks for linear_table_interpolation_core, bound to the top.
// Depends on ltic_pkg.
module ltic_chk import ltic_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_req_type,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] out_result_value,
  input logic             out_in_range
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_result_value) && $stable(out_in_range))
    else $error("result beat changed while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_QUERY |=> !in_ready)
    else $error("input taken while a query is in progress");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_LOAD |=> in_ready)
    else $error("load beat stalled the input");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> out_result_value == '0)
    else $error("out-of-range result is not zero");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the result and free the input");

endmodule

bind linear_table_interpolation_core ltic_chk u_ltic_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_req_type      (in_ch.req_type),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_value (out_ch.result_value),
  .out_in_range     (out_ch.in_range)
);
